// File: rtl/merge_sort_engine_defines.svh
// Assertion macros for the merge sort engine.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: whenever cond holds, prop holds too.
`define MSE_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication: when cond holds, prop holds in the next cycle.
`define MSE_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`else

`define MSE_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define MSE_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// File: rtl/mse_pkg.sv
package mse_pkg;

   // Element width and default buffer depth.
   localparam int VALUE_WIDTH      = 32;
   localparam int DEFAULT_CAPACITY = 64;

endpackage

// File: rtl/mse_ram.sv
module mse_ram
   import mse_pkg::*;
#(
   parameter int WIDTH = VALUE_WIDTH,
   parameter int DEPTH = DEFAULT_CAPACITY
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/merge_sort_engine.sv
// Merge sort engine.
// Requests carry one signed 32-bit value each; a request is taken at a clock
// edge with start high and busy low. Loading takes one request per cycle and
// returns nothing. The request flagged req_final_item starts a stable
// ascending bottom-up merge sort of the stored values (at most CAPACITY;
// later values are dropped and rsp_overflow is raised on the whole batch).
// Sorting ping-pongs between two single-port-read RAM banks. In each pass,
// every element taken costs a write and, while its run has more, a refill
// read of that run's head; each run pair first reads its two heads. The
// single read port per bank sets the cost over ceil(log2 n) passes. Results
// then stream out one per cycle with rsp_valid, the last with rsp_end_of_run.
// busy is high from the final request until the last read is issued; a new
// request may be taken in the cycle that shows the last result.
// The receiver cannot stall: each result is on the ports for one cycle.
// Synchronous reset clears the element count, the overflow flag and the
// sequencer; RAM contents are not cleared.
`include "merge_sort_engine_defines.svh"

module merge_sort_engine
   import mse_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_final_item,
   output logic                   rsp_valid,
   output logic [VALUE_WIDTH-1:0] rsp_sorted_value,
   output logic                   rsp_end_of_run,
   output logic                   rsp_overflow
);

   localparam int CW = $clog2(CAPACITY + 1);   // count and index values
   localparam int IW = $clog2(CAPACITY);       // RAM address
   localparam int WW = CW + 1;                 // run width, stays below 2*CAPACITY
   localparam int SW = CW + 2;                 // sums of index and run width

   typedef enum logic [2:0] {
      S_IDLE, S_PAIR, S_RD_L, S_RD_R, S_MERGE, S_FILL, S_NEXT, S_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [WW-1:0]    width_ff, width_in;
   logic [CW-1:0]    lo_ff, lo_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [CW-1:0]    l_ff, l_in, r_ff, r_in, k_ff, k_in;
   logic [CW-1:0]    out_idx_ff, out_idx_in;
   logic [VALUE_WIDTH-1:0] lhead_ff, lhead_in, rhead_ff, rhead_in;
   logic             fill_left_ff, fill_left_in;
   logic             src_ff, src_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_eor_ff, rsp_eor_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic                   rd_en, ld_we, mrg_we;
   logic [CW-1:0]          rd_addr, wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data, rd_data, rd_data_a, rd_data_b;
   logic [SW-1:0]          sum_lo_w, sum_lo_2w;
   logic [CW-1:0]          mid_calc, hi_calc, l_next, r_next, k_next;
   logic [WW-1:0]          width_dbl;
   logic                   take_left, has_room;

   // Bank A holds loaded values; passes alternate between A and B.
   mse_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_bank_a (
      .clock   (clock),
      .wr_en   (ld_we | (mrg_we & src_ff)),
      .wr_addr (wr_addr[IW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en & ~src_ff),
      .rd_addr (rd_addr[IW-1:0]),
      .rd_data (rd_data_a)
   );

   mse_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_bank_b (
      .clock   (clock),
      .wr_en   (mrg_we & ~src_ff),
      .wr_addr (wr_addr[IW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en & src_ff),
      .rd_addr (rd_addr[IW-1:0]),
      .rd_data (rd_data_b)
   );

   assign rd_data = src_ff ? rd_data_b : rd_data_a;

   // Run bounds, clipped to the element count.
   assign sum_lo_w  = SW'(lo_ff) + SW'(width_ff);
   assign sum_lo_2w = sum_lo_w + SW'(width_ff);
   assign mid_calc  = (sum_lo_w > SW'(n_ff)) ? n_ff : sum_lo_w[CW-1:0];
   assign hi_calc   = (sum_lo_2w > SW'(n_ff)) ? n_ff : sum_lo_2w[CW-1:0];
   assign width_dbl = {width_ff[WW-2:0], 1'b0};

   assign l_next = l_ff + CW'(1);
   assign r_next = r_ff + CW'(1);
   assign k_next = k_ff + CW'(1);
   assign has_room = (count_ff < CW'(CAPACITY));

   // Take the left head on ties to keep the sort stable.
   assign take_left = (l_ff < mid_ff) &&
                      ((r_ff >= hi_ff) || ($signed(lhead_ff) <= $signed(rhead_ff)));

   assign wr_addr = ld_we ? count_ff : k_ff;
   assign wr_data = ld_we ? req_value : (take_left ? lhead_ff : rhead_ff);

   // Sequence load, merge passes and readout.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      n_in         = n_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      out_idx_in   = out_idx_ff;
      lhead_in     = lhead_ff;
      rhead_in     = rhead_ff;
      fill_left_in = fill_left_ff;
      src_in       = src_ff;
      rsp_valid_in = 1'b0;
      rsp_eor_in   = rsp_eor_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      ld_we        = 1'b0;
      mrg_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               // store the value, or drop it when the buffer is full
               if (has_room) begin
                  ld_we    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_final_item) begin
                  n_in       = has_room ? count_ff + CW'(1) : count_ff;
                  src_in     = 1'b0;
                  width_in   = WW'(1);
                  lo_in      = '0;
                  out_idx_in = '0;
                  state_in   = (WW'(1) < WW'(n_in)) ? S_PAIR : S_OUT;
               end
            end
         end
         S_PAIR: begin
            l_in     = lo_ff;
            r_in     = mid_calc;
            k_in     = lo_ff;
            mid_in   = mid_calc;
            hi_in    = hi_calc;
            rd_en    = 1'b1;
            rd_addr  = lo_ff;
            state_in = S_RD_L;
         end
         S_RD_L: begin
            lhead_in = rd_data;
            if (r_ff < hi_ff) begin
               rd_en   = 1'b1;
               rd_addr = r_ff;
            end
            state_in = S_RD_R;
         end
         S_RD_R: begin
            rhead_in = rd_data;
            state_in = S_MERGE;
         end
         S_MERGE: begin
            // write the smaller head, refill from its run
            mrg_we = 1'b1;
            k_in   = k_next;
            if (take_left) begin
               l_in = l_next;
               if (l_next < mid_ff) begin
                  rd_en        = 1'b1;
                  rd_addr      = l_next;
                  fill_left_in = 1'b1;
                  state_in     = S_FILL;
               end else if (k_next == hi_ff) begin
                  state_in = S_NEXT;
               end
            end else begin
               r_in = r_next;
               if (r_next < hi_ff) begin
                  rd_en        = 1'b1;
                  rd_addr      = r_next;
                  fill_left_in = 1'b0;
                  state_in     = S_FILL;
               end else if (k_next == hi_ff) begin
                  state_in = S_NEXT;
               end
            end
         end
         S_FILL: begin
            if (fill_left_ff) begin
               lhead_in = rd_data;
            end else begin
               rhead_in = rd_data;
            end
            state_in = S_MERGE;
         end
         S_NEXT: begin
            // advance to the next pair, or to the next pass
            if (sum_lo_2w < SW'(n_ff)) begin
               lo_in    = sum_lo_2w[CW-1:0];
               state_in = S_PAIR;
            end else begin
               width_in   = width_dbl;
               src_in     = ~src_ff;
               lo_in      = '0;
               out_idx_in = '0;
               state_in   = (width_dbl < WW'(n_ff)) ? S_PAIR : S_OUT;
            end
         end
         S_OUT: begin
            rd_en        = 1'b1;
            rd_addr      = out_idx_ff;
            rsp_valid_in = 1'b1;
            rsp_eor_in   = (out_idx_ff + CW'(1) == n_ff);
            rsp_ovf_in   = dropped_ff;
            out_idx_in   = out_idx_ff + CW'(1);
            if (out_idx_ff + CW'(1) == n_ff) begin
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         src_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      width_ff     <= width_in;
      lo_ff        <= lo_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      l_ff         <= l_in;
      r_ff         <= r_in;
      k_ff         <= k_in;
      out_idx_ff   <= out_idx_in;
      lhead_ff     <= lhead_in;
      rhead_ff     <= rhead_in;
      fill_left_ff <= fill_left_in;
      rsp_eor_ff   <= rsp_eor_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rd_data;
   assign rsp_end_of_run   = rsp_eor_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   `MSE_ASSERT_NEXT(a_full_drops, clock, reset,
      start && !busy && (count_ff == CW'(CAPACITY)), dropped_ff)
   `MSE_ASSERT_IMPLY(a_merge_in_run, clock, reset,
      state_ff == S_MERGE, (k_ff < hi_ff) && ((l_ff < mid_ff) || (r_ff < hi_ff)))
   `MSE_ASSERT_IMPLY(a_last_clears, clock, reset,
      rsp_valid_ff && rsp_eor_ff, (state_ff == S_IDLE) && (count_ff == '0) && !dropped_ff)
   `MSE_ASSERT_IMPLY(a_batch_nonempty, clock, reset,
      busy, (n_ff != '0) && (n_ff <= CW'(CAPACITY)))
   `MSE_ASSERT_IMPLY(a_no_write_clash, clock, reset,
      ld_we, !mrg_we)

endmodule
